// File: rtl/ctwt_pkg.sv
// ----------------------------------------------------------------------------
// ctwt_pkg: shared types and codes for the client table
// Opcodes, status codes, the table entry layout and the compare unit result.
// ----------------------------------------------------------------------------
package ctwt_pkg;

   typedef logic [31:0] addr_type;
   typedef logic [15:0] port_type;
   typedef logic [47:0] key_type;
   typedef logic [31:0] time_type;
   typedef logic [15:0] timeout_type;
   typedef logic [1:0]  status_type;

   typedef enum logic [1:0] {
      OP_ADD       = 2'd0,
      OP_CONTAINS  = 2'd1,
      OP_REFRESH   = 2'd2,
      OP_BROADCAST = 2'd3
   } op_type;

   localparam status_type STATUS_OK     = 2'd0;
   localparam status_type STATUS_ABSENT = 2'd1;
   localparam status_type STATUS_FULL   = 2'd2;

   localparam timeout_type TIMEOUT_RESET = 16'd5;

   // One table slot as held in memory
   typedef struct packed {
      logic     valid;
      addr_type addr;
      port_type port;
      time_type stamp;
   } entry_type;

   // Per-entry verdicts from the shared compare unit
   typedef struct packed {
      logic hit;
      logic expired;
      logic gt_prev;
      logic lt_best;
   } cmp_type;

endpackage

// File: rtl/ctwt_req_if.sv
// ----------------------------------------------------------------------------
// ctwt_req_if: request channel of the client table
// Valid/ready handshake carrying the opcode, the client key and the time.
// ----------------------------------------------------------------------------
interface ctwt_req_if import ctwt_pkg::*; ();
   logic     valid;
   logic     ready;
   logic [1:0] opcode;
   addr_type client_addr;
   port_type client_port;
   time_type now;

   modport source (output valid, output opcode, output client_addr,
                   output client_port, output now, input ready);
   modport sink (input valid, input opcode, input client_addr,
                 input client_port, input now, output ready);
endinterface

// File: rtl/ctwt_rsp_if.sv
// ----------------------------------------------------------------------------
// ctwt_rsp_if: response channel of the client table
// Valid/ready handshake carrying status, broadcast target and last flag.
// ----------------------------------------------------------------------------
interface ctwt_rsp_if import ctwt_pkg::*; ();
   logic       valid;
   logic       ready;
   status_type status;
   logic       client_valid;
   addr_type   out_addr;
   port_type   out_port;
   logic       last;

   modport source (output valid, output status, output client_valid,
                   output out_addr, output out_port, output last, input ready);
   modport sink (input valid, input status, input client_valid,
                 input out_addr, input out_port, input last, output ready);
endinterface

// File: rtl/ctwt_mem.sv
// ----------------------------------------------------------------------------
// ctwt_mem: client table storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ctwt_mem import ctwt_pkg::*; #(
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  entry_type     wr_data,
   input  logic [AW-1:0] rd_addr,
   output entry_type     rd_data
);

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/ctwt_cmp.sv
// ----------------------------------------------------------------------------
// ctwt_cmp: shared compare unit
// Judges one table entry: key match, age against the timeout, and its order
// against the previous and current best broadcast keys.
// ----------------------------------------------------------------------------
module ctwt_cmp import ctwt_pkg::*; (
   input  entry_type   entry,
   input  addr_type    key_addr,
   input  port_type    key_port,
   input  time_type    now,
   input  timeout_type timeout,
   input  key_type     prev_key,
   input  key_type     best_key,
   output cmp_type     result
);

   key_type  entry_key;
   time_type age;

   assign entry_key = {entry.addr, entry.port};
   // wrap-around age, compared unsigned
   assign age       = now - entry.stamp;

   always_comb begin
      result.hit     = entry.valid && (entry.addr == key_addr) && (entry.port == key_port);
      result.expired = age > {16'd0, timeout};
      result.gt_prev = entry_key > prev_key;
      result.lt_best = entry_key < best_key;
   end

endmodule

// File: rtl/client_table_with_timeout_unit.sv
// ----------------------------------------------------------------------------
// client_table_with_timeout_unit: aging client table
// Holds up to CAPACITY (address, port) clients with last-seen stamps and
// walks them one entry per cycle through a shared compare unit.
//
//   channel | role   | handshake            | contents
//   req     | input  | valid/ready          | opcode, client key, now
//   rsp     | output | valid/ready          | status, target, last
//   csr     | config | write enable only    | timeout_seconds
//
// Add, contains, refresh: one table walk per request;
//   contains and refresh stop early at a hit.
// Broadcast: one aging walk, then one walk per live client; each walk is
//   one memory read a cycle.
// After reset a clearing pass over every entry runs before req.ready rises.
// A stalled rsp holds the sequencer; one request is in work at a time.
// ----------------------------------------------------------------------------
module client_table_with_timeout_unit import ctwt_pkg::*; #(
   parameter int CAPACITY = 64
) (
   input  logic           clock,
   input  logic           reset,
   ctwt_req_if.sink       req,
   ctwt_rsp_if.source     rsp,
   input  logic           csr_wr_en,
   input  timeout_type    csr_wr_data
);

   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_ADD_SCAN, ST_LOOK_SCAN, ST_AGE_SCAN, ST_MIN_SCAN, ST_REPLY
   } state_type;

   state_type   state_ff, state_in;
   op_type      op_ff, op_in;
   addr_type    key_addr_ff, key_addr_in;
   port_type    key_port_ff, key_port_in;
   time_type    now_ff, now_in;
   timeout_type timeout_ff, timeout_in;
   logic [IW-1:0] rd_idx_ff, rd_idx_in;
   logic [IW-1:0] eval_idx_ff, eval_idx_in;
   logic        eval_vld_ff, eval_vld_in;
   logic        found_ff, found_in;
   logic        free_vld_ff, free_vld_in;
   logic [IW-1:0] free_idx_ff, free_idx_in;
   logic [CW-1:0] live_cnt_ff, live_cnt_in;
   logic [CW-1:0] remain_ff, remain_in;
   key_type     prev_key_ff, prev_key_in;
   logic        have_prev_ff, have_prev_in;
   key_type     best_key_ff, best_key_in;
   logic        best_vld_ff, best_vld_in;
   status_type  rep_status_ff, rep_status_in;
   logic        rep_valid_ff, rep_valid_in;
   key_type     rep_key_ff, rep_key_in;
   logic        rep_last_ff, rep_last_in;
   logic        rsp_valid_ff, rsp_valid_in;
   status_type  rsp_status_ff, rsp_status_in;
   logic        rsp_cvalid_ff, rsp_cvalid_in;
   key_type     rsp_key_ff, rsp_key_in;
   logic        rsp_last_ff, rsp_last_in;

   logic          mem_wr_en;
   logic [IW-1:0] mem_wr_addr;
   entry_type     mem_wr_data;
   entry_type     rd_entry;
   cmp_type       cmp;

   logic          walk_end;
   logic          found_now;
   logic          free_now;
   logic [IW-1:0] free_at;
   logic [CW-1:0] live_now;
   logic          cand;
   key_type       best_now;
   logic          reply_load;

   ctwt_mem #(.DEPTH(CAPACITY)) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (rd_idx_ff),
      .rd_data (rd_entry)
   );

   ctwt_cmp u_cmp (
      .entry    (rd_entry),
      .key_addr (key_addr_ff),
      .key_port (key_port_ff),
      .now      (now_ff),
      .timeout  (timeout_ff),
      .prev_key (prev_key_ff),
      .best_key (best_key_ff),
      .result   (cmp)
   );

   assign req.ready         = (state_ff == ST_IDLE);
   assign rsp.valid         = rsp_valid_ff;
   assign rsp.status        = rsp_status_ff;
   assign rsp.client_valid  = rsp_cvalid_ff;
   assign rsp.out_addr      = rsp_key_ff[47:16];
   assign rsp.out_port      = rsp_key_ff[15:0];
   assign rsp.last          = rsp_last_ff;

   assign walk_end  = eval_vld_ff && (eval_idx_ff == LAST_IDX);
   assign found_now = found_ff || (eval_vld_ff && cmp.hit);
   assign free_now  = free_vld_ff || (eval_vld_ff && !rd_entry.valid);
   assign free_at   = free_vld_ff ? free_idx_ff : eval_idx_ff;
   assign live_now  = live_cnt_ff
                    + CW'(eval_vld_ff && rd_entry.valid && !cmp.expired);
   assign cand      = eval_vld_ff && rd_entry.valid && (!have_prev_ff || cmp.gt_prev)
                    && (!best_vld_ff || cmp.lt_best);
   assign best_now  = cand ? {rd_entry.addr, rd_entry.port} : best_key_ff;
   assign reply_load = (state_ff == ST_REPLY) && (!rsp_valid_ff || rsp.ready);

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_addr_in   = key_addr_ff;
      key_port_in   = key_port_ff;
      now_in        = now_ff;
      timeout_in    = csr_wr_en ? csr_wr_data : timeout_ff;
      rd_idx_in     = rd_idx_ff;
      eval_idx_in   = eval_idx_ff;
      eval_vld_in   = eval_vld_ff;
      found_in      = found_ff;
      free_vld_in   = free_vld_ff;
      free_idx_in   = free_idx_ff;
      live_cnt_in   = live_cnt_ff;
      remain_in     = remain_ff;
      prev_key_in   = prev_key_ff;
      have_prev_in  = have_prev_ff;
      best_key_in   = best_key_ff;
      best_vld_in   = best_vld_ff;
      rep_status_in = rep_status_ff;
      rep_valid_in  = rep_valid_ff;
      rep_key_in    = rep_key_ff;
      rep_last_in   = rep_last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_status_in = rsp_status_ff;
      rsp_cvalid_in = rsp_cvalid_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_last_in   = rsp_last_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = eval_idx_ff;
      mem_wr_data   = rd_entry;

      // advance the read pipeline while walking
      if (state_ff == ST_ADD_SCAN || state_ff == ST_LOOK_SCAN ||
          state_ff == ST_AGE_SCAN || state_ff == ST_MIN_SCAN) begin
         rd_idx_in   = (rd_idx_ff == LAST_IDX) ? rd_idx_ff : rd_idx_ff + IW'(1);
         eval_idx_in = rd_idx_ff;
         eval_vld_in = 1'b1;
      end

      case (state_ff)
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = rd_idx_ff;
            mem_wr_data = '0;
            if (rd_idx_ff == LAST_IDX) begin
               rd_idx_in = '0;
               state_in  = ST_IDLE;
            end else begin
               rd_idx_in = rd_idx_ff + IW'(1);
            end
         end
         ST_IDLE: begin
            if (req.valid) begin
               op_in        = op_type'(req.opcode);
               key_addr_in  = req.client_addr;
               key_port_in  = req.client_port;
               now_in       = req.now;
               rd_idx_in    = '0;
               eval_vld_in  = 1'b0;
               found_in     = 1'b0;
               free_vld_in  = 1'b0;
               live_cnt_in  = '0;
               rep_valid_in = 1'b0;
               rep_key_in   = '0;
               rep_last_in  = 1'b1;
               case (op_type'(req.opcode))
                  OP_ADD:       state_in = ST_ADD_SCAN;
                  OP_CONTAINS:  state_in = ST_LOOK_SCAN;
                  OP_REFRESH:   state_in = ST_LOOK_SCAN;
                  OP_BROADCAST: state_in = ST_AGE_SCAN;
                  default:      state_in = ST_IDLE;
               endcase
            end
         end
         ST_ADD_SCAN: begin
            found_in    = found_now;
            free_vld_in = free_now;
            free_idx_in = free_at;
            if (walk_end) begin
               state_in = ST_REPLY;
               if (found_now) begin
                  rep_status_in = STATUS_OK;
               end else if (free_now) begin
                  mem_wr_en     = 1'b1;
                  mem_wr_addr   = free_at;
                  mem_wr_data   = '{valid: 1'b1, addr: key_addr_ff,
                                    port: key_port_ff, stamp: now_ff};
                  rep_status_in = STATUS_OK;
               end else begin
                  rep_status_in = STATUS_FULL;
               end
            end
         end
         ST_LOOK_SCAN: begin
            if (eval_vld_ff && cmp.hit) begin
               state_in = ST_REPLY;
               if (cmp.expired) begin
                  // drop the stale entry
                  mem_wr_en         = 1'b1;
                  mem_wr_data.valid = 1'b0;
                  rep_status_in     = STATUS_ABSENT;
               end else begin
                  mem_wr_en         = (op_ff == OP_REFRESH);
                  mem_wr_data.stamp = now_ff;
                  rep_status_in     = STATUS_OK;
               end
            end else if (walk_end) begin
               state_in      = ST_REPLY;
               rep_status_in = STATUS_ABSENT;
            end
         end
         ST_AGE_SCAN: begin
            live_cnt_in = live_now;
            if (eval_vld_ff && rd_entry.valid && cmp.expired) begin
               mem_wr_en         = 1'b1;
               mem_wr_data.valid = 1'b0;
            end
            if (walk_end) begin
               if (live_now == '0) begin
                  rep_status_in = STATUS_ABSENT;
                  state_in      = ST_REPLY;
               end else begin
                  remain_in    = live_now;
                  have_prev_in = 1'b0;
                  best_vld_in  = 1'b0;
                  rd_idx_in    = '0;
                  eval_vld_in  = 1'b0;
                  state_in     = ST_MIN_SCAN;
               end
            end
         end
         ST_MIN_SCAN: begin
            if (cand) begin
               best_vld_in = 1'b1;
               best_key_in = best_now;
            end
            if (walk_end) begin
               rep_status_in = STATUS_OK;
               rep_valid_in  = 1'b1;
               rep_key_in    = best_now;
               rep_last_in   = (remain_ff == CW'(1));
               prev_key_in   = best_now;
               have_prev_in  = 1'b1;
               remain_in     = remain_ff - CW'(1);
               state_in      = ST_REPLY;
            end
         end
         ST_REPLY: begin
            if (reply_load) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = rep_status_ff;
               rsp_cvalid_in = rep_valid_ff;
               rsp_key_in    = rep_key_ff;
               rsp_last_in   = rep_last_ff;
               if (op_ff == OP_BROADCAST && !rep_last_ff) begin
                  best_vld_in = 1'b0;
                  rd_idx_in   = '0;
                  eval_vld_in = 1'b0;
                  state_in    = ST_MIN_SCAN;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         timeout_ff   <= TIMEOUT_RESET;
         rd_idx_ff    <= '0;
         eval_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         timeout_ff   <= timeout_in;
         rd_idx_ff    <= rd_idx_in;
         eval_vld_ff  <= eval_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      key_addr_ff   <= key_addr_in;
      key_port_ff   <= key_port_in;
      now_ff        <= now_in;
      eval_idx_ff   <= eval_idx_in;
      found_ff      <= found_in;
      free_vld_ff   <= free_vld_in;
      free_idx_ff   <= free_idx_in;
      live_cnt_ff   <= live_cnt_in;
      remain_ff     <= remain_in;
      prev_key_ff   <= prev_key_in;
      have_prev_ff  <= have_prev_in;
      best_key_ff   <= best_key_in;
      best_vld_ff   <= best_vld_in;
      rep_status_ff <= rep_status_in;
      rep_valid_ff  <= rep_valid_in;
      rep_key_ff    <= rep_key_in;
      rep_last_ff   <= rep_last_in;
      rsp_status_ff <= rsp_status_in;
      rsp_cvalid_ff <= rsp_cvalid_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_last_ff   <= rsp_last_in;
   end

`ifndef SYNTHESIS
   a_min_walk_finds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MIN_SCAN && walk_end) |-> (best_vld_ff || cand))
      else $error("broadcast walk ended without a candidate");

   a_min_remain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MIN_SCAN) |-> (remain_ff != '0))
      else $error("broadcast walk with no clients left");

   a_more_follows: assert property (@(posedge clock) disable iff (reset)
      (reply_load && op_ff == OP_BROADCAST && !rep_last_ff) |=> (state_ff == ST_MIN_SCAN))
      else $error("broadcast stopped before its last response");

   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE || state_ff == ST_REPLY) |-> !mem_wr_en)
      else $error("table written outside a walk");
`endif

endmodule
